[rtl/dtts_pkg.sv]
// Package: shared types and constants of the depth-two tree split selector.
package dtts_pkg;

  localparam int unsigned MaxFeatures = 256;
  localparam int unsigned FeatW = $clog2(MaxFeatures);
  localparam logic [31:0] PenNone = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    FUNC_CLEAR = 3'd0,
    FUNC_DIAG  = 3'd1,
    FUNC_PAIR  = 3'd2,
    FUNC_CLOSE = 3'd3,
    FUNC_REPORT = 3'd4
  } func_e;

  typedef struct packed {
    logic [31:0] error;
    logic [7:0]  feature;
    logic        found;
    logic        left;
    logic        right;
  } best_t;

  // child table entry: left and right penalties, valid bits (bit 0 left, bit 1 right)
  typedef struct packed {
    logic [31:0] left_pen;
    logic [31:0] right_pen;
    logic [1:0]  valid;
  } child_t;

  // diagonal table entry
  typedef struct packed {
    logic [31:0] zero_pen;
    logic [31:0] one_pen;
    logic [1:0]  events;
  } diag_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? PenNone : s[31:0];
  endfunction

endpackage

[rtl/dtts_ram.sv]
// Single-port-write, single-read synchronous RAM with registered read data.
module dtts_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

[rtl/depth_two_tree_split_selector.sv]
// Top level: depth-two tree split selector.
// Requests arrive on the in channel (in_valid_i / in_stall_o) with func selecting
// clear, diagonal load, feature pair, row close or report. Report requests emit
// three results (budget 1, 2, 3; last on the third) on the out channel
// (out_valid_o / out_stall_i). leaf_error is written over the APB port.
// Per-feature state sits in two RAMs (diagonal penalties and events; child
// penalties with their valid bits), each read through a registered port.
// Diagonal, close and unused codes pass S_RD and S_EXEC; pair adds S_RD_B and
// S_EXEC_B (one RAM read-modify-write per feature); clear passes S_RD and
// S_EXEC, then S_WIPE wipes the child valid bits of all 256 entries. Report:
// each result is registered in S_REPORT once the output register is free, one
// result per cycle while the receiver takes them; the next request is taken
// the cycle after the third result is issued. The sequencer works on one
// request at a time; a stalled receiver holds the result register and, during
// a report, the block. Reset loads all three bests with leaf error 0xFFFFFFFF
// and runs the same wipe, with in_stall_o high throughout.
module depth_two_tree_split_selector
  import dtts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [7:0]  feat_a_i,
  input  logic [7:0]  feat_b_i,
  input  logic [31:0] pen_zero_zero_i,
  input  logic [31:0] pen_zero_one_i,
  input  logic [31:0] pen_one_zero_i,
  input  logic [31:0] pen_one_one_i,
  input  logic [3:0]  event_flags_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  budget_o,
  output logic        found_o,
  output logic [7:0]  best_feature_o,
  output logic [31:0] best_error_o,
  output logic        left_nodes_o,
  output logic        right_nodes_o,
  output logic        last_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EXEC, S_RD_B, S_EXEC_B, S_REPORT, S_WIPE
  } state_e;

  state_e state_q;
  logic [31:0] leaf_q;
  best_t b1_q, b2_q, b3_q;
  logic [2:0] func_q;
  logic [7:0] fa_q, fb_q;
  logic [31:0] p00_q, p01_q, p10_q, p11_q;
  logic [3:0] ev_q;
  logic [1:0] cnt_q;
  logic [FeatW-1:0] wipe_q;
  // pending child offers for feat_b, computed in first pass
  logic ob_l_q, ob_r_q;
  logic [31:0] ob_lp_q, ob_rp_q;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? leaf_q : 32'd0;

  // RAM ports
  logic           d_we, c_we;
  logic [FeatW-1:0] d_waddr, c_waddr, d_raddr, c_raddr;
  diag_t  d_wdata, d_rdata;
  child_t c_wdata, c_rdata;

  dtts_ram #(.Width($bits(diag_t)), .Depth(MaxFeatures)) u_diag (
    .clk_i, .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .raddr_i(d_raddr), .rdata_o(d_rdata)
  );
  dtts_ram #(.Width($bits(child_t)), .Depth(MaxFeatures)) u_child (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr), .rdata_o(c_rdata)
  );

  logic [FeatW-1:0] cur_f;
  assign cur_f = (state_q == S_RD_B || state_q == S_EXEC_B) ? fb_q : fa_q;
  assign d_raddr = cur_f;
  assign c_raddr = cur_f;

  // child update for the current feature
  logic [1:0]  cv, cv_new;
  logic        off_l, off_r, upd_l, upd_r;
  logic [31:0] off_lp, off_rp, new_l, new_r;
  logic [31:0] cand_l, cand_r, cand3;
  logic        en_l_a, en_r_a;

  always_comb begin
    cv = c_rdata.valid;
    en_l_a = ev_q[1] & ev_q[0];
    en_r_a = ev_q[3] & ev_q[2];
    if (state_q == S_EXEC_B) begin
      off_l = ob_l_q; off_r = ob_r_q; off_lp = ob_lp_q; off_rp = ob_rp_q;
    end else begin
      off_l = en_l_a; off_r = en_r_a;
      off_lp = sat_add(p01_q, p00_q); off_rp = sat_add(p11_q, p10_q);
    end
    upd_l = off_l && (!cv[0] || off_lp < c_rdata.left_pen);
    upd_r = off_r && (!cv[1] || off_rp < c_rdata.right_pen);
    new_l = upd_l ? off_lp : c_rdata.left_pen;
    new_r = upd_r ? off_rp : c_rdata.right_pen;
    cv_new = cv | {upd_r, upd_l};
    cand_l = sat_add(new_l, d_rdata.one_pen);
    cand_r = sat_add(new_r, d_rdata.zero_pen);
    cand3 = sat_add(c_rdata.left_pen, c_rdata.right_pen);
  end

  logic is_pair_exec;
  assign is_pair_exec = (func_q == FUNC_PAIR) && (state_q == S_EXEC || state_q == S_EXEC_B);
  assign c_we = (state_q == S_WIPE) || (is_pair_exec && (upd_l || upd_r));
  assign c_waddr = (state_q == S_WIPE) ? wipe_q : cur_f;

  always_comb begin
    if (state_q == S_WIPE) begin
      c_wdata = '0;
    end else begin
      c_wdata = '{left_pen: new_l, right_pen: new_r, valid: cv_new};
    end
  end

  assign d_we = (state_q == S_EXEC) && (func_q == FUNC_DIAG);
  assign d_waddr = fa_q;
  assign d_wdata = '{zero_pen: p00_q, one_pen: p11_q, events: {ev_q[3], ev_q[0]}};

  logic out_free;
  assign out_free = !out_valid_o || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // two-node offer with strict ordering: left first then right
  function automatic best_t offer(input best_t b, input logic en, input logic [31:0] e,
                                  input logic [7:0] f, input logic l, input logic r);
    best_t n;
    n = b;
    if (en && e < b.error) begin
      n = '{error: e, feature: f, found: 1'b1, left: l, right: r};
    end
    return n;
  endfunction

  best_t two_a, two_b, cur_best;
  logic root_ok;
  logic [7:0] cur_f8;
  always_comb begin
    cur_f8 = 8'(cur_f);
    root_ok = (d_rdata.events == 2'b11);
    two_a = offer(b2_q, root_ok & cv_new[0], cand_l, cur_f8, 1'b1, 1'b0);
    two_b = offer(two_a, root_ok & cv_new[1], cand_r, cur_f8, 1'b0, 1'b1);
    unique case (cnt_q)
      2'd0:    cur_best = b1_q;
      2'd1:    cur_best = b2_q;
      default: cur_best = b3_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_WIPE;
      wipe_q <= '0;
      leaf_q <= PenNone;
      b1_q <= '{error: PenNone, default: '0};
      b2_q <= '{error: PenNone, default: '0};
      b3_q <= '{error: PenNone, default: '0};
      out_valid_o <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (psel && penable && pwrite && paddr == 2'd0) leaf_q <= pwdata;
      if (out_valid_o && !out_stall_i && state_q != S_REPORT) out_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            func_q <= func_i; fa_q <= feat_a_i; fb_q <= feat_b_i;
            p00_q <= pen_zero_zero_i; p01_q <= pen_zero_one_i;
            p10_q <= pen_one_zero_i; p11_q <= pen_one_one_i;
            ev_q <= event_flags_i;
            cnt_q <= 2'd0;
            state_q <= (func_i == FUNC_REPORT) ? S_REPORT : S_RD;
          end
        end
        S_RD: state_q <= S_EXEC;
        S_EXEC: begin
          priority case (func_q)
            FUNC_CLEAR: begin
              b1_q <= '{error: leaf_q, default: '0};
              b2_q <= '{error: leaf_q, default: '0};
              b3_q <= '{error: leaf_q, default: '0};
              wipe_q <= '0;
              state_q <= S_WIPE;
            end
            FUNC_DIAG: begin
              b1_q <= offer(b1_q, ev_q[0] & ev_q[3], sat_add(p00_q, p11_q),
                            fa_q, 1'b0, 1'b0);
              state_q <= S_IDLE;
            end
            FUNC_PAIR: begin
              ob_l_q <= ev_q[2] & ev_q[0];
              ob_r_q <= ev_q[3] & ev_q[1];
              ob_lp_q <= sat_add(p10_q, p00_q);
              ob_rp_q <= sat_add(p11_q, p01_q);
              // same feature twice: try the root once all child offers are in
              if (fa_q != fb_q) b2_q <= two_b;
              state_q <= S_RD_B;
            end
            FUNC_CLOSE: begin
              b3_q <= offer(b3_q, cv == 2'b11, cand3, fa_q, 1'b1, 1'b1);
              state_q <= S_IDLE;
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_RD_B: state_q <= S_EXEC_B;
        S_EXEC_B: begin
          b2_q <= two_b;
          state_q <= S_IDLE;
        end
        S_REPORT: begin
          if (out_free) begin
            out_valid_o <= 1'b1;
            budget_o <= cnt_q + 2'd1;
            found_o <= cur_best.found;
            best_feature_o <= cur_best.found ? cur_best.feature : 8'd0;
            best_error_o <= cur_best.error;
            left_nodes_o <= cur_best.found & cur_best.left;
            right_nodes_o <= cur_best.found & cur_best.right;
            last_o <= (cnt_q == 2'd2);
            cnt_q <= cnt_q + 2'd1;
            if (cnt_q == 2'd2) state_q <= S_IDLE;
          end
        end
        S_WIPE: begin
          wipe_q <= wipe_q + FeatW'(1);
          if (wipe_q == FeatW'(MaxFeatures - 1)) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
